@@ src/cps_pkg.sv @@
// Shared types and constants for the closest-point-on-segment pipeline.
package cps_pkg;

    // Coordinate format: signed Q16.16
    localparam int CW = 32;
    // Difference of two coordinates, one bit wider
    localparam int VW = CW + 1;
    // Product of two difference magnitudes
    localparam int PW = 2 * VW - 1;
    // Sum of three products, also the divider remainder width
    localparam int SW = PW + 2;
    // Fraction bits of the projection ratio
    localparam int RB = 60;
    // Ratio width, holds 0 .. 2^RB
    localparam int QW = RB + 1;
    // Split of the ratio for the two partial products
    localparam int QLO = 30;
    localparam int QHI = QW - QLO;

    // Region codes
    localparam logic [1:0] REGION_INTERIOR = 2'd0;
    localparam logic [1:0] REGION_START    = 2'd1;
    localparam logic [1:0] REGION_END      = 2'd2;
    localparam logic [1:0] REGION_DEGEN    = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_START_Z = 3'd2;
    localparam logic [2:0] CFG_END_X   = 3'd3;
    localparam logic [2:0] CFG_END_Y   = 3'd4;
    localparam logic [2:0] CFG_END_Z   = 3'd5;

    // Reset value of the end point coordinates (1.0)
    localparam logic signed [CW-1:0] END_RESET = 32'sd65536;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
        logic signed [CW-1:0] query_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [CW-1:0] near_x;
        logic signed [CW-1:0] near_y;
        logic signed [CW-1:0] near_z;
        logic [1:0]           region;
    } t_out_beat;

endpackage

@@ src/closest_point_on_segment.sv @@
// Top level: fully pipelined nearest point on a configured 3D segment.
// Throughput: one beat per cycle; the long path is the restoring divider,
// one quotient bit per stage over 61 stages, plus two split multiplies.
// The whole pipeline advances together and holds while the output is stalled.
// Reset (synchronous, active low) clears all valid bits, the start point to 0
// and the end point to 1.0 on each axis.
module closest_point_on_segment
    import cps_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  t_in_beat       i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_out_beat      o_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [CW-1:0]  i_cfg_data
);

    // Configuration registers
    logic signed [CW-1:0] r_start [3];
    logic signed [CW-1:0] r_end   [3];

    // Segment direction and squared length, refreshed every cycle
    logic [VW-1:0] r_vmag [3];
    logic          r_vneg [3];
    logic [PW-1:0] r_vsq  [3];
    logic [SW-1:0] r_len;

    logic en;

    // Stage 1: offset from start
    logic          r1_valid;
    logic [VW-1:0] r1_cmag [3];
    logic          r1_cneg [3];
    // Stage 2: products
    logic          r2_valid;
    logic [PW-1:0] r2_p    [3];
    logic          r2_pneg [3];
    // Stage 3: positive and negative sums
    logic          r3_valid;
    logic [SW-1:0] r3_pos;
    logic [SW-1:0] r3_neg;
    // Stage 4: dot magnitude and sign
    logic          r4_valid;
    logic          r4_dotneg;
    logic [SW-1:0] r4_dot;
    // Divider stages: 0 is the region decision and leading quotient bit, 1..RB the remaining quotient bits
    logic          r_dv_valid  [RB+1];
    logic [1:0]    r_dv_region [RB+1];
    logic [SW-1:0] r_dv_rem    [RB+1];
    logic [QW-1:0] r_dv_frac   [RB+1];
    logic [SW-1:0] n_dv_rem    [RB+1];
    logic [QW-1:0] n_dv_frac   [RB+1];
    // Multiply stage
    logic            r6_valid;
    logic [1:0]      r6_region;
    logic [VW+QHI-1:0] r6_phi [3];
    logic [VW+QLO-1:0] r6_plo [3];
    // Combine stage
    logic          r7_valid;
    logic [1:0]    r7_region;
    logic [VW-1:0] r7_off [3];
    // Output register
    logic          r_out_valid;
    t_out_beat     r_out;

    logic signed [CW-1:0] q [3];
    logic signed [CW-1:0] n_near [3];

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign q[0] = i_in_data.query_x;
    assign q[1] = i_in_data.query_y;
    assign q[2] = i_in_data.query_z;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_start[k] <= '0;
                r_end[k]   <= END_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X: r_start[0] <= i_cfg_data;
                CFG_START_Y: r_start[1] <= i_cfg_data;
                CFG_START_Z: r_start[2] <= i_cfg_data;
                CFG_END_X:   r_end[0]   <= i_cfg_data;
                CFG_END_Y:   r_end[1]   <= i_cfg_data;
                CFG_END_Z:   r_end[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Track direction magnitude, its square and the squared length
    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] v;
        for (int k = 0; k < 3; k++) begin
            v = {r_end[k][CW-1], r_end[k]} - {r_start[k][CW-1], r_start[k]};
            r_vneg[k] <= v[VW-1];
            r_vmag[k] <= v[VW-1] ? VW'(-v) : VW'(v);
            r_vsq[k]  <= r_vmag[k] * r_vmag[k];
        end
        r_len <= SW'(r_vsq[0]) + SW'(r_vsq[1]) + SW'(r_vsq[2]);
    end

    // Valid bits for all stages, divider stages included
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j <= RB; j++) r_dv_valid[j] <= 1'b0;
        end else if (en) begin
            r1_valid      <= i_in_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r_dv_valid[0] <= r4_valid;
            for (int j = 1; j <= RB; j++) r_dv_valid[j] <= r_dv_valid[j-1];
            r6_valid      <= r_dv_valid[RB];
            r7_valid      <= r6_valid;
            r_out_valid   <= r7_valid;
        end
    end

    // Front stages: offset, products, sums, dot magnitude and sign
    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] c;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                c = {q[k][CW-1], q[k]} - {r_start[k][CW-1], r_start[k]};
                r1_cneg[k] <= c[VW-1];
                r1_cmag[k] <= c[VW-1] ? VW'(-c) : VW'(c);
                r2_p[k]    <= r1_cmag[k] * r_vmag[k];
                r2_pneg[k] <= r1_cneg[k] ^ r_vneg[k];
            end
            r3_pos <= (r2_pneg[0] ? '0 : SW'(r2_p[0]))
                    + (r2_pneg[1] ? '0 : SW'(r2_p[1]))
                    + (r2_pneg[2] ? '0 : SW'(r2_p[2]));
            r3_neg <= (r2_pneg[0] ? SW'(r2_p[0]) : '0)
                    + (r2_pneg[1] ? SW'(r2_p[1]) : '0)
                    + (r2_pneg[2] ? SW'(r2_p[2]) : '0);
            r4_dotneg <= r3_pos < r3_neg;
            r4_dot    <= (r3_pos < r3_neg) ? r3_neg - r3_pos : r3_pos - r3_neg;
        end
    end

    // Leading quotient bit and the restoring step of every further divider stage
    always_comb begin
        logic ge;
        ge = r4_dot >= r_len;
        n_dv_rem[0]  = ge ? r4_dot - r_len : r4_dot;
        n_dv_frac[0] = QW'(ge);
        for (int j = 1; j <= RB; j++) begin
            logic [SW-1:0] sh;
            logic          bit_ge;
            sh           = {r_dv_rem[j-1][SW-2:0], 1'b0};
            bit_ge       = sh >= r_len;
            n_dv_rem[j]  = bit_ge ? sh - r_len : sh;
            n_dv_frac[j] = {r_dv_frac[j-1][QW-2:0], bit_ge};
        end
    end

    // Make the region decision and advance the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_len == '0)
                r_dv_region[0] <= REGION_DEGEN;
            else if (r4_dotneg)
                r_dv_region[0] <= REGION_START;
            else if (r4_dot > r_len)
                r_dv_region[0] <= REGION_END;
            else
                r_dv_region[0] <= REGION_INTERIOR;
            for (int j = 0; j <= RB; j++) begin
                r_dv_rem[j]  <= n_dv_rem[j];
                r_dv_frac[j] <= n_dv_frac[j];
            end
            for (int j = 1; j <= RB; j++) r_dv_region[j] <= r_dv_region[j-1];
        end
    end

    // Scale the direction by the ratio, then round to the offset
    always_ff @(posedge i_clk) begin
        logic [VW+QW+QLO-1:0] sum;
        if (en) begin
            r6_region <= r_dv_region[RB];
            r7_region <= r6_region;
            for (int k = 0; k < 3; k++) begin
                r6_phi[k] <= r_vmag[k] * r_dv_frac[RB][QW-1:QLO];
                r6_plo[k] <= r_vmag[k] * r_dv_frac[RB][QLO-1:0];
                sum = ((VW+QW+QLO)'(r6_phi[k]) << QLO) + (VW+QW+QLO)'(r6_plo[k])
                    + ((VW+QW+QLO)'(1) << (RB - 1));
                r7_off[k] <= sum[RB+VW-1:RB];
            end
        end
    end

    // Select the point and saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [VW:0] res;
            case (r7_region)
                REGION_INTERIOR: begin
                    if (r_vneg[k])
                        res = {{2{r_start[k][CW-1]}}, r_start[k]} - {1'b0, r7_off[k]};
                    else
                        res = {{2{r_start[k][CW-1]}}, r_start[k]} + {1'b0, r7_off[k]};
                end
                REGION_END: res = {{2{r_end[k][CW-1]}}, r_end[k]};
                default:    res = {{2{r_start[k][CW-1]}}, r_start[k]};
            endcase
            if (res > (VW+1)'($signed({1'b0, {(CW-1){1'b1}}})))
                n_near[k] = {1'b0, {(CW-1){1'b1}}};
            else if (res < $signed({{2{1'b1}}, 1'b1, {(CW-1){1'b0}}}))
                n_near[k] = {1'b1, {(CW-1){1'b0}}};
            else
                n_near[k] = res[CW-1:0];
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.near_x <= n_near[0];
            r_out.near_y <= n_near[1];
            r_out.near_z <= n_near[2];
            r_out.region <= r7_region;
        end
    end

    // Ratio never exceeds one for an interior beat
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[RB] && r_dv_region[RB] == REGION_INTERIOR
        |-> r_dv_frac[RB] <= (QW'(1) << RB))
        else $error("projection ratio above one");

    // Divider remainder stays below the squared length
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[RB] && r_dv_region[RB] == REGION_INTERIOR
        |-> r_dv_rem[RB] < r_len)
        else $error("divider remainder out of range");

    // A degenerate segment reports the start point
    a_degen_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.region == REGION_DEGEN
        |-> o_out_data.near_x == r_start[0] && o_out_data.near_y == r_start[1]
            && o_out_data.near_z == r_start[2])
        else $error("degenerate beat not at start");

    // Clamping past the end reports the end point
    a_end_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.region == REGION_END
        |-> o_out_data.near_x == r_end[0] && o_out_data.near_y == r_end[1]
            && o_out_data.near_z == r_end[2])
        else $error("end-clamped beat not at end");

endmodule
